// File: rtl/tekd_pkg.sv
// ----------------------------------------------------------------------------
// tekd_pkg
// Shared types, codes and tables for the terminal escape key decoder.
// ----------------------------------------------------------------------------
package tekd_pkg;

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_ESC   = 3'd1;
  localparam logic [2:0] PH_CSI   = 3'd2;
  localparam logic [2:0] PH_SS3   = 3'd3;
  localparam logic [2:0] PH_DIGIT = 3'd4;

  localparam logic [7:0] KEY_ESC        = 8'd0;
  localparam logic [7:0] KEY_UP         = 8'd1;
  localparam logic [7:0] KEY_DOWN       = 8'd2;
  localparam logic [7:0] KEY_RIGHT      = 8'd3;
  localparam logic [7:0] KEY_LEFT       = 8'd4;
  localparam logic [7:0] KEY_LINE_START = 8'd5;
  localparam logic [7:0] KEY_END        = 8'd6;
  localparam logic [7:0] KEY_INS        = 8'd7;
  localparam logic [7:0] KEY_DEL        = 8'd8;
  localparam logic [7:0] KEY_PGUP       = 8'd9;
  localparam logic [7:0] KEY_PGDN       = 8'd10;
  localparam logic [7:0] KEY_BKSP       = 8'd11;

  localparam logic       KIND_BYTE = 1'b0;
  localparam logic       KIND_KEY  = 1'b1;

  localparam logic       CMD_BYTE  = 1'b0;
  localparam logic       CMD_TICK  = 1'b1;

  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_O     = 8'h4F;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_SIX   = 8'h36;

  localparam logic [15:0] TIMEOUT_RESET = 16'd100;
  localparam logic [15:0] TICKS_MAX     = 16'hFFFF;

  typedef struct packed {
    logic [2:0]  phase;
    logic [2:0]  digit;
    logic [15:0] elapsed;
  } dec_state_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] value;
  } key_res_t;

  // Final letter of a cursor sequence; valid is low when the byte is no such letter.
  function automatic logic [8:0] letter_key(input logic [7:0] b);
    logic [8:0] r;
    r = {1'b0, KEY_ESC};
    unique case (b)
      8'h41:   r = {1'b1, KEY_UP};
      8'h42:   r = {1'b1, KEY_DOWN};
      8'h43:   r = {1'b1, KEY_RIGHT};
      8'h44:   r = {1'b1, KEY_LEFT};
      8'h48:   r = {1'b1, KEY_LINE_START};
      8'h46:   r = {1'b1, KEY_END};
      default: r = {1'b0, KEY_ESC};
    endcase
    return r;
  endfunction

  function automatic logic [7:0] digit_key(input logic [2:0] d);
    logic [7:0] r;
    r = KEY_ESC;
    unique case (d)
      3'd1:    r = KEY_LINE_START;
      3'd2:    r = KEY_INS;
      3'd3:    r = KEY_DEL;
      3'd4:    r = KEY_END;
      3'd5:    r = KEY_PGUP;
      3'd6:    r = KEY_PGDN;
      default: r = KEY_ESC;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/tekd_decode.sv
// ----------------------------------------------------------------------------
// tekd_decode
// Next state and key result for one byte or tick request.
// ----------------------------------------------------------------------------
module tekd_decode
  import tekd_pkg::*;
(
  input  dec_state_t  state,
  input  logic [15:0] timeout_ticks,
  input  logic        cmd,
  input  logic [7:0]  rx_byte,
  output dec_state_t  state_next,
  output logic        res_valid,
  output key_res_t    res
);

  logic        active;
  logic [15:0] elapsed_inc;
  logic [8:0]  letter;
  logic        is_digit;
  dec_state_t  cleared;

  assign active      = (state.phase >= PH_ESC) && (state.phase <= PH_DIGIT);
  assign elapsed_inc = (state.elapsed < TICKS_MAX) ? state.elapsed + 16'd1 : state.elapsed;
  assign letter      = letter_key(rx_byte);
  assign is_digit    = (rx_byte >= CH_ONE) && (rx_byte <= CH_SIX);
  assign cleared     = '{phase: PH_IDLE, digit: 3'd0, elapsed: 16'd0};

  always_comb begin
    state_next = active ? state : cleared;
    res_valid  = 1'b0;
    res        = '{kind: KIND_KEY, value: KEY_ESC};
    if (cmd == CMD_TICK) begin
      if (active) begin
        state_next.elapsed = elapsed_inc;
        if (elapsed_inc >= timeout_ticks) begin
          state_next = cleared;
          res_valid  = 1'b1;
        end
      end
    end else begin
      res_valid  = 1'b1;
      state_next = cleared;
      unique case (state.phase)
        PH_ESC: begin
          if (rx_byte == CH_LBRK) begin
            res_valid        = 1'b0;
            state_next       = state;
            state_next.phase = PH_CSI;
          end else if (rx_byte == CH_O) begin
            res_valid        = 1'b0;
            state_next       = state;
            state_next.phase = PH_SS3;
          end
        end
        PH_CSI: begin
          if (letter[8]) begin
            res.value = letter[7:0];
          end else if (is_digit) begin
            res_valid        = 1'b0;
            state_next       = state;
            state_next.phase = PH_DIGIT;
            state_next.digit = rx_byte[2:0];
          end
        end
        PH_SS3: begin
          if (letter[8]) begin
            res.value = letter[7:0];
          end
        end
        PH_DIGIT: begin
          if (rx_byte == CH_TILDE) begin
            res.value = digit_key(state.digit);
          end
        end
        default: begin
          if (rx_byte == CH_ESC) begin
            res_valid        = 1'b0;
            state_next.phase = PH_ESC;
          end else if ((rx_byte == CH_DEL) || (rx_byte == CH_BS)) begin
            res.value = KEY_BKSP;
          end else begin
            res.kind  = KIND_BYTE;
            res.value = rx_byte;
          end
        end
      endcase
    end
  end

endmodule

// File: rtl/tekd_out_buf.sv
// ----------------------------------------------------------------------------
// tekd_out_buf
// Two-entry result buffer: an output register backed by a skid register.
// ----------------------------------------------------------------------------
module tekd_out_buf
  import tekd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  key_res_t push_data,
  output logic     full,
  output logic     out_valid,
  input  logic     out_stall,
  output key_res_t out_data
);

  logic     skid_valid;
  key_res_t skid_data;
  logic     slot_free;

  assign slot_free = !out_valid || !out_stall;
  assign full      = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (slot_free) begin
      out_valid  <= skid_valid || push;
      skid_valid <= skid_valid && push;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free) begin
      if (skid_valid) begin
        out_data  <= skid_data;
        skid_data <= push_data;
      end else begin
        out_data <= push_data;
      end
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

// File: rtl/terminal_escape_key_decoder_core.sv
// ----------------------------------------------------------------------------
// terminal_escape_key_decoder_core
// Turns received terminal bytes and time ticks into plain bytes and named keys.
// ----------------------------------------------------------------------------
//  channel  signals                      handshake
//  in       cmd, rx_byte                 in_valid / in_stall
//  out      key_kind, key_value          out_valid / out_stall
//  cfg      cfg_data (timeout_ticks)     cfg_valid / cfg_ready
//
// One request is taken every cycle while in_stall is low; any key it yields is registered in the output buffer.
// The sequence state updates in the same cycle the request is taken.
// A skid register holds a second key, so input stalls only when both are full.
// Reset returns to idle with a timeout of 100 ticks.
module terminal_escape_key_decoder_core
  import tekd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        cmd,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        key_kind,
  output logic [7:0]  key_value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  dec_state_t  state;
  dec_state_t  state_next;
  logic [15:0] timeout_ticks;
  logic        res_valid;
  key_res_t    res;
  key_res_t    out_data;
  logic        full;
  logic        accept;

  assign cfg_ready = 1'b1;
  assign in_stall  = full;
  assign accept    = in_valid && !full;
  assign key_kind  = out_data.kind;
  assign key_value = out_data.value;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      timeout_ticks <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{phase: PH_IDLE, digit: 3'd0, elapsed: 16'd0};
    end else if (accept) begin
      state <= state_next;
    end
  end

  tekd_decode u_decode (
    .state         (state),
    .timeout_ticks (timeout_ticks),
    .cmd           (cmd),
    .rx_byte       (rx_byte),
    .state_next    (state_next),
    .res_valid     (res_valid),
    .res           (res)
  );

  tekd_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept && res_valid),
    .push_data (res),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the terminal escape key decoder. A scoreboard class
// predicts every key from the requests that the decoder accepts and checks
// each key that leaves it. Stimulus is a short directed set, then random key
// sequences mixed with noise, broken sequences and ticks, under several
// timeout settings, with random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tekd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned ITEMS_PER_SETTING = 160;

  class key_scoreboard;
    logic [2:0]  phase;
    logic [2:0]  digit;
    logic [15:0] elapsed;
    logic [15:0] timeout;
    key_res_t    expected_keys[$];
    int unsigned errors;
    int unsigned keys_checked;
    int unsigned named_keys;

    function new();
      phase = PH_IDLE;
      digit = 3'd0;
      elapsed = 16'd0;
      timeout = TIMEOUT_RESET;
      errors = 0;
      keys_checked = 0;
      named_keys = 0;
    endfunction

    function void set_timeout(logic [15:0] v);
      timeout = v;
    endfunction

    function int unsigned pending();
      return expected_keys.size();
    endfunction

    function logic [8:0] cursor_key(logic [7:0] b);
      case (b)
        "A": return {1'b1, KEY_UP};
        "B": return {1'b1, KEY_DOWN};
        "C": return {1'b1, KEY_RIGHT};
        "D": return {1'b1, KEY_LEFT};
        "H": return {1'b1, KEY_LINE_START};
        "F": return {1'b1, KEY_END};
        default: return {1'b0, KEY_ESC};
      endcase
    endfunction

    function logic [7:0] tilde_key(logic [2:0] d);
      case (d)
        3'd1: return KEY_LINE_START;
        3'd2: return KEY_INS;
        3'd3: return KEY_DEL;
        3'd4: return KEY_END;
        3'd5: return KEY_PGUP;
        3'd6: return KEY_PGDN;
        default: return KEY_ESC;
      endcase
    endfunction

    function void finish_key(logic kind, logic [7:0] value);
      key_res_t k;
      k.kind = kind;
      k.value = value;
      expected_keys.push_back(k);
      phase = PH_IDLE;
      digit = 3'd0;
      elapsed = 16'd0;
    endfunction

    function void note_request(logic c, logic [7:0] b);
      logic       in_seq;
      logic [8:0] hit;
      in_seq = (phase >= PH_ESC) && (phase <= PH_DIGIT);
      if (!in_seq) begin
        phase = PH_IDLE;
        digit = 3'd0;
        elapsed = 16'd0;
      end
      if (c == CMD_TICK) begin
        if (in_seq) begin
          if (elapsed != TICKS_MAX) elapsed = elapsed + 16'd1;
          if (elapsed >= timeout) finish_key(KIND_KEY, KEY_ESC);
        end
        return;
      end
      hit = cursor_key(b);
      case (phase)
        PH_ESC: begin
          if (b == CH_LBRK) phase = PH_CSI;
          else if (b == CH_O) phase = PH_SS3;
          else finish_key(KIND_KEY, KEY_ESC);
        end
        PH_CSI: begin
          if (hit[8]) begin
            finish_key(KIND_KEY, hit[7:0]);
          end else if (b >= CH_ONE && b <= CH_SIX) begin
            digit = 3'(b - CH_ONE + 8'd1);
            phase = PH_DIGIT;
          end else begin
            finish_key(KIND_KEY, KEY_ESC);
          end
        end
        PH_SS3: begin
          if (hit[8]) finish_key(KIND_KEY, hit[7:0]);
          else finish_key(KIND_KEY, KEY_ESC);
        end
        PH_DIGIT: begin
          if (b == CH_TILDE) finish_key(KIND_KEY, tilde_key(digit));
          else finish_key(KIND_KEY, KEY_ESC);
        end
        default: begin
          if (b == CH_ESC) begin
            phase = PH_ESC;
            digit = 3'd0;
            elapsed = 16'd0;
          end else if (b == CH_DEL || b == CH_BS) begin
            finish_key(KIND_KEY, KEY_BKSP);
          end else begin
            finish_key(KIND_BYTE, b);
          end
        end
      endcase
    endfunction

    function void check_key(logic kind, logic [7:0] value);
      key_res_t want;
      if (expected_keys.size() == 0) begin
        errors++;
        $display("%0t: key with nothing expected, actual kind %0d value %0d",
                 $time, kind, value);
        return;
      end
      want = expected_keys.pop_front();
      keys_checked++;
      if (want.kind == KIND_KEY) named_keys++;
      if (kind !== want.kind) begin
        errors++;
        $display("%0t: key_kind expected %0d actual %0d", $time, want.kind, kind);
      end
      if (value !== want.value) begin
        errors++;
        $display("%0t: key_value expected %0d actual %0d", $time, want.value, value);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        cmd = CMD_BYTE;
  logic [7:0]  rx_byte = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        key_kind;
  logic [7:0]  key_value;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = 16'd0;

  key_scoreboard sb = new();

  int unsigned cycles = 0;
  int unsigned items_sent = 0;
  int unsigned settings_used = 0;
  int unsigned burst_left = 0;
  int unsigned hold_off_cycles = 0;
  logic        offering = 1'b0;

  terminal_escape_key_decoder_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .rx_byte   (rx_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .key_kind  (key_kind),
    .key_value (key_value),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb_top: errors");
    $finish;
  end

  // The receiver checks keys and stalls on a changing pattern, or holds off on request.
  initial begin
    int unsigned mode;
    int unsigned mode_left;
    int unsigned beat;
    mode = 0;
    mode_left = 40;
    beat = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) sb.check_key(key_kind, key_value);
      beat++;
      if (mode_left == 0) begin
        mode = $urandom_range(0, 4);
        mode_left = $urandom_range(20, 200);
      end else begin
        mode_left--;
      end
      if (hold_off_cycles > 0) begin
        hold_off_cycles--;
        out_stall <= 1'b1;
      end else begin
        case (mode)
          1: out_stall <= ($urandom_range(0, 99) < 25);
          2: out_stall <= (beat % 3 == 0);
          3: out_stall <= ($urandom_range(0, 99) < 75);
          4: out_stall <= (beat % 8 < 5);
          default: out_stall <= 1'b0;
        endcase
      end
    end
  end

  task automatic send_request(input logic c, input logic [7:0] b);
    if (!offering) begin
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 30);
    end
    in_valid <= 1'b1;
    cmd <= c;
    rx_byte <= b;
    offering = 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_request(c, b);
    items_sent++;
    burst_left--;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      offering = 1'b0;
    end
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_request(CMD_BYTE, b);
  endtask

  task automatic send_tick();
    send_request(CMD_TICK, 8'($urandom_range(0, 255)));
  endtask

  task automatic wait_drained();
    if (offering) begin
      in_valid <= 1'b0;
      offering = 1'b0;
      burst_left = 0;
    end
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [15:0] v);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_timeout(v);
    settings_used++;
  endtask

  function automatic logic [7:0] random_letter();
    case ($urandom_range(0, 5))
      0: return "A";
      1: return "B";
      2: return "C";
      3: return "D";
      4: return "H";
      default: return "F";
    endcase
  endfunction

  task automatic maybe_ticks();
    if ($urandom_range(0, 99) < 15) begin
      repeat ($urandom_range(1, 3)) send_tick();
    end
  endtask

  task automatic send_key_sequence();
    send_byte(CH_ESC);
    maybe_ticks();
    case ($urandom_range(0, 2))
      0: begin
        send_byte(CH_LBRK);
        maybe_ticks();
        send_byte(random_letter());
      end
      1: begin
        send_byte(CH_LBRK);
        maybe_ticks();
        send_byte(CH_ONE + 8'($urandom_range(0, 5)));
        maybe_ticks();
        send_byte(CH_TILDE);
      end
      default: begin
        send_byte(CH_O);
        maybe_ticks();
        send_byte(random_letter());
      end
    endcase
  endtask

  task automatic send_noise();
    int unsigned n;
    case ($urandom_range(0, 7))
      0: send_byte(8'($urandom_range(0, 255)));
      1: send_tick();
      2: begin
        send_byte(CH_ESC);
        send_byte(8'($urandom_range(0, 255)));
      end
      3: begin
        send_byte(CH_ESC);
        send_byte(CH_LBRK);
        send_byte(8'($urandom_range(0, 255)));
      end
      4: begin
        send_byte(CH_ESC);
        send_byte(CH_LBRK);
        send_byte(CH_ONE + 8'($urandom_range(0, 5)));
        send_byte(8'($urandom_range(0, 255)));
      end
      5: begin
        send_byte(CH_ESC);
        send_byte(CH_O);
        send_byte(8'($urandom_range(0, 255)));
      end
      6: begin
        send_byte(CH_ESC);
        if (sb.timeout == 16'd0) n = 1;
        else if (sb.timeout <= 16'd24) n = sb.timeout;
        else n = $urandom_range(1, 4);
        repeat (n) send_tick();
      end
      default: begin
        send_byte(CH_ESC);
        send_byte(CH_ESC);
      end
    endcase
  endtask

  task automatic run_random(input int unsigned count);
    int unsigned stop_at;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 99) < 70) send_key_sequence();
      else send_noise();
    end
  endtask

  initial begin
    logic [15:0] settings[8];
    settings = '{16'd65535, 16'd2, 16'd0, 16'd5, 16'd1, 16'd3, 16'd100,
                 16'($urandom_range(4, 20))};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(CH_DEL);
    send_byte(CH_BS);
    send_byte("a");
    send_tick();
    send_byte(CH_ESC);
    send_byte(CH_LBRK);
    send_byte("A");
    send_byte(CH_ESC);
    send_byte(CH_LBRK);
    send_byte("3");
    send_byte(CH_TILDE);
    send_byte(CH_ESC);
    send_byte(CH_O);
    send_byte("F");
    send_byte(CH_ESC);
    send_byte(CH_LBRK);
    send_byte("7");
    send_byte(CH_ESC);
    send_byte(CH_ESC);
    write_timeout(16'd1);
    send_byte(CH_ESC);
    send_tick();
    write_timeout(16'd0);
    send_byte(CH_ESC);
    send_tick();

    foreach (settings[i]) begin
      write_timeout(settings[i]);
      run_random(ITEMS_PER_SETTING / 2);
      if (i == 0) begin
        hold_off_cycles = 80;
        repeat (16) send_byte(8'h20 + 8'($urandom_range(0, 90)));
      end
      if (i == 3) wait_drained();
      run_random(ITEMS_PER_SETTING / 2);
    end

    wait_drained();
    repeat (10) @(posedge clk);
    $display("summary: %0d requests sent, %0d keys checked (%0d named)",
             items_sent, sb.keys_checked, sb.named_keys);
    $display("summary: %0d timeout settings written, %0d keys still owed",
             settings_used, sb.pending());
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

// File: terminal_escape_key_decoder_core.f
rtl/tekd_pkg.sv
rtl/tekd_decode.sv
rtl/tekd_out_buf.sv
rtl/terminal_escape_key_decoder_core.sv
tb/sv/tb_top.sv
